/* rtl/core/rbst_pkg.sv */
// Shared types and constants for the ray versus box slab test.
// Holds the per-axis slab result struct, the interval limits and the register indexes.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package rbst_pkg;

  // Signed Q16.16 coordinate or distance.
  typedef logic signed [31:0] fix_t;

  // The interval starts at the widest range a 32-bit distance can hold.
  localparam fix_t T_NEAR_START = 32'sh8000_0000;
  localparam fix_t T_FAR_START  = 32'sh7fff_ffff;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_INV_DIR_X  = 3'd3,
    REG_INV_DIR_Y  = 3'd4,
    REG_INV_DIR_Z  = 3'd5,
    REG_PARALLEL   = 3'd6
  } reg_index_t;

  // What one axis contributes to the running interval.
  typedef struct packed {
    logic pass;     // parallel axis check passed, or axis not parallel
    fix_t t_enter;  // lower slab distance, or the near start value
    fix_t t_exit;   // upper slab distance, or the far start value
  } slab_t;

endpackage

/* rtl/core/rbst_slab_lane.sv */
// One axis of the slab test: two slab distances, their ordering and the parallel check.
// Uses rbst_pkg for the slab_t struct and the interval start values.
`timescale 1ns / 1ps

module rbst_slab_lane (
  input  logic signed [31:0] bound_lo,
  input  logic signed [31:0] bound_hi,
  input  logic signed [31:0] origin,
  input  logic signed [31:0] inv_dir,
  input  logic               parallel,
  output rbst_pkg::slab_t    slab
);

  logic signed [32:0] diff_lo;
  logic signed [32:0] diff_hi;
  logic signed [64:0] prod_lo;
  logic signed [64:0] prod_hi;
  logic signed [31:0] t_lo;
  logic signed [31:0] t_hi;
  logic               in_slab;

  // Drop the 16 fraction bits with an arithmetic shift (floor), then saturate to 32 bits.
  function automatic logic signed [31:0] scale_sat(input logic signed [64:0] p);
    logic signed [48:0] q;
    q = p[64:16];
    if (q[48:31] == {18{1'b0}} || q[48:31] == {18{1'b1}}) begin
      scale_sat = q[31:0];
    end else if (q[48]) begin
      scale_sat = rbst_pkg::T_NEAR_START;
    end else begin
      scale_sat = rbst_pkg::T_FAR_START;
    end
  endfunction

  // Exact differences and products, one multiplier per bound.
  assign diff_lo = {bound_lo[31], bound_lo} - {origin[31], origin};
  assign diff_hi = {bound_hi[31], bound_hi} - {origin[31], origin};
  assign prod_lo = 65'(diff_lo) * 65'(inv_dir);
  assign prod_hi = 65'(diff_hi) * 65'(inv_dir);
  assign t_lo    = scale_sat(prod_lo);
  assign t_hi    = scale_sat(prod_hi);

  // Origin inside the slab, used only when the axis is flagged parallel.
  assign in_slab = (origin >= bound_lo) && (origin <= bound_hi);

  // A parallel axis leaves the interval untouched; otherwise order the two distances.
  always_comb begin
    slab.pass = 1'b1;
    if (parallel) begin
      slab.pass    = in_slab;
      slab.t_enter = rbst_pkg::T_NEAR_START;
      slab.t_exit  = rbst_pkg::T_FAR_START;
    end else if (t_lo > t_hi) begin
      slab.t_enter = t_hi;
      slab.t_exit  = t_lo;
    end else begin
      slab.t_enter = t_lo;
      slab.t_exit  = t_hi;
    end
  end

endmodule

/* rtl/core/rbst_fold.sv */
// Folds the three per-axis slab results into hit, near and far distances.
// Uses rbst_pkg for the slab_t struct.
`timescale 1ns / 1ps

module rbst_fold (
  input  rbst_pkg::slab_t    slab_x,
  input  rbst_pkg::slab_t    slab_y,
  input  rbst_pkg::slab_t    slab_z,
  output logic               hit,
  output logic signed [31:0] t_near,
  output logic signed [31:0] t_far
);

  logic signed [31:0] near_xy;
  logic signed [31:0] far_xy;
  logic signed [31:0] near_all;
  logic signed [31:0] far_all;

  // Near only grows and far only shrinks, so one check at the end matches the
  // axis-by-axis fold.
  assign near_xy  = (slab_y.t_enter > slab_x.t_enter) ? slab_y.t_enter : slab_x.t_enter;
  assign far_xy   = (slab_y.t_exit  < slab_x.t_exit)  ? slab_y.t_exit  : slab_x.t_exit;
  assign near_all = (slab_z.t_enter > near_xy) ? slab_z.t_enter : near_xy;
  assign far_all  = (slab_z.t_exit  < far_xy)  ? slab_z.t_exit  : far_xy;

  // A miss reports zero distances.
  assign hit    = slab_x.pass && slab_y.pass && slab_z.pass && (near_all <= far_all);
  assign t_near = hit ? near_all : 32'sd0;
  assign t_far  = hit ? far_all  : 32'sd0;

endmodule

/* rtl/core/ray_box_slab_test.sv */
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_slab_lane and rbst_fold.
`timescale 1ns / 1ps

// Tests one box per item against the ray held in the configuration registers and
// returns hit, entry and exit distances in signed Q16.16 (both zero on a miss).
// Each box is held in the input register, from which six 33 by 32 bit
// multipliers (two per axis) with the floor, saturation and interval fold form
// the path to the result register; the block takes one box every cycle while
// the output is not stalled, and each result waits in the result register until
// it is taken. The ray registers are
// written through the configuration port,
// which is always ready; they must only change while no box is in flight.
// The host sets a bit of parallel_axes for each axis whose direction is
// below its epsilon.
module ray_box_slab_test (
  input  logic               clk,
  input  logic               rst,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // Box input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  // Result output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] t_near,
  output logic signed [31:0] t_far
);

  // Ray registers
  logic signed [31:0] ray_origin_x;
  logic signed [31:0] ray_origin_y;
  logic signed [31:0] ray_origin_z;
  logic signed [31:0] ray_inv_dir_x;
  logic signed [31:0] ray_inv_dir_y;
  logic signed [31:0] ray_inv_dir_z;
  logic [2:0]         parallel_axes;

  // Input register
  logic               box_valid;
  logic signed [31:0] box_lo_x;
  logic signed [31:0] box_lo_y;
  logic signed [31:0] box_lo_z;
  logic signed [31:0] box_hi_x;
  logic signed [31:0] box_hi_y;
  logic signed [31:0] box_hi_z;

  // Combinational results
  rbst_pkg::slab_t    slab_x;
  rbst_pkg::slab_t    slab_y;
  rbst_pkg::slab_t    slab_z;
  logic               hit_next;
  logic signed [31:0] t_near_next;
  logic signed [31:0] t_far_next;

  logic               res_load;
  logic               box_load;

  // The configuration port never holds off a write.
  assign cfg_ready = 1'b1;

  // Configuration register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_origin_x  <= '0;
      ray_origin_y  <= '0;
      ray_origin_z  <= '0;
      ray_inv_dir_x <= '0;
      ray_inv_dir_y <= '0;
      ray_inv_dir_z <= '0;
      parallel_axes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rbst_pkg::reg_index_t'(cfg_index))
        rbst_pkg::REG_ORIGIN_X:  ray_origin_x  <= cfg_data;
        rbst_pkg::REG_ORIGIN_Y:  ray_origin_y  <= cfg_data;
        rbst_pkg::REG_ORIGIN_Z:  ray_origin_z  <= cfg_data;
        rbst_pkg::REG_INV_DIR_X: ray_inv_dir_x <= cfg_data;
        rbst_pkg::REG_INV_DIR_Y: ray_inv_dir_y <= cfg_data;
        rbst_pkg::REG_INV_DIR_Z: ray_inv_dir_z <= cfg_data;
        rbst_pkg::REG_PARALLEL:  parallel_axes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Flow control: the result register loads when empty or when its item is taken,
  // and the input register moves on whenever the result register loads.
  assign res_load = !out_valid || !out_stall;
  assign in_stall = box_valid && !res_load;
  assign box_load = !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (box_load) begin
      box_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (box_load && in_valid) begin
      box_lo_x <= box_min_x;
      box_lo_y <= box_min_y;
      box_lo_z <= box_min_z;
      box_hi_x <= box_max_x;
      box_hi_y <= box_max_y;
      box_hi_z <= box_max_z;
    end
  end

  // One lane per axis
  rbst_slab_lane u_lane_x (
    .bound_lo (box_lo_x),
    .bound_hi (box_hi_x),
    .origin   (ray_origin_x),
    .inv_dir  (ray_inv_dir_x),
    .parallel (parallel_axes[0]),
    .slab     (slab_x)
  );

  rbst_slab_lane u_lane_y (
    .bound_lo (box_lo_y),
    .bound_hi (box_hi_y),
    .origin   (ray_origin_y),
    .inv_dir  (ray_inv_dir_y),
    .parallel (parallel_axes[1]),
    .slab     (slab_y)
  );

  rbst_slab_lane u_lane_z (
    .bound_lo (box_lo_z),
    .bound_hi (box_hi_z),
    .origin   (ray_origin_z),
    .inv_dir  (ray_inv_dir_z),
    .parallel (parallel_axes[2]),
    .slab     (slab_z)
  );

  // Interval fold across the three axes
  rbst_fold u_fold (
    .slab_x (slab_x),
    .slab_y (slab_y),
    .slab_z (slab_z),
    .hit    (hit_next),
    .t_near (t_near_next),
    .t_far  (t_far_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= box_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && box_valid) begin
      hit    <= hit_next;
      t_near <= t_near_next;
      t_far  <= t_far_next;
    end
  end

endmodule

/* sim/ray_box_slab_test_tb.sv */
// Self-checking testbench for the ray versus axis-aligned box slab test.
// Depends on rbst_pkg and ray_box_slab_test; it needs no files and no arguments.
// A table of directed boxes is followed by random ray settings and boxes.
`timescale 1ns / 1ps

module ray_box_slab_test_tb;

  typedef rbst_pkg::fix_t fix_t;

  localparam fix_t ONE = 32'sh0001_0000;
  localparam fix_t FIX_MIN = rbst_pkg::T_NEAR_START;
  localparam fix_t FIX_MAX = rbst_pkg::T_FAR_START;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int RANDOM_PHASES = 10;
  localparam int BOXES_PER_PHASE = 85;

  typedef struct packed {
    fix_t [2:0] org;
    fix_t [2:0] inv;
    logic [2:0] par;
  } ray_t;

  typedef struct packed {
    fix_t [2:0] lo;
    fix_t [2:0] hi;
  } box_t;

  typedef struct packed {
    logic hit;
    fix_t t_near;
    fix_t t_far;
  } span_t;

  typedef struct packed {
    logic [2:0] ray_sel;
    box_t       box;
    logic       known;
    span_t      want;
  } box_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  fix_t        box_min_x, box_min_y, box_min_z;
  fix_t        box_max_x, box_max_y, box_max_z;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  fix_t        t_near;
  fix_t        t_far;

  // The ray as the block should currently hold it, and the spans still owed.
  ray_t        cur_ray;
  span_t       expected_spans[$];
  box_row_t    directed_rows[$];
  ray_t        rays[5];

  int          error_count;
  int          spans_checked;
  int          hits_seen;
  int          ray_settings;
  bit          send_busy;
  bit          recv_busy;
  int          stall_left;

  ray_box_slab_test dut (.*);

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard limit on the length of the run.
  initial begin
    #5_000_000;
    $display("ray_box_slab_test_tb: errors");
    $finish;
  end

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (!busy || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One slab distance: exact difference and product, floor to Q16.16, saturate.
  function automatic fix_t slab_distance(input fix_t bound, input fix_t org, input fix_t inv);
    longint diff, prod, q;
    diff = longint'(bound) - longint'(org);
    prod = diff * longint'(inv);
    q = prod >>> 16;
    if (q > longint'(FIX_MAX)) return FIX_MAX;
    if (q < longint'(FIX_MIN)) return FIX_MIN;
    return fix_t'(q);
  endfunction

  // Expected result of one box against the given ray.
  function automatic span_t predict_span(input ray_t r, input box_t b);
    fix_t  org_i, lo_i, hi_i, t_lo, t_hi, swap, near_t, far_t;
    logic  ok;
    int    i;
    span_t s;
    near_t = FIX_MIN;
    far_t = FIX_MAX;
    ok = 1'b1;
    for (i = 0; i < 3; i++) begin
      org_i = r.org[i];
      lo_i = b.lo[i];
      hi_i = b.hi[i];
      if (r.par[i]) begin
        // A parallel axis only asks whether the origin sits inside the slab.
        if (org_i < lo_i || org_i > hi_i) ok = 1'b0;
      end else begin
        t_lo = slab_distance(lo_i, org_i, r.inv[i]);
        t_hi = slab_distance(hi_i, org_i, r.inv[i]);
        if (t_lo > t_hi) begin
          swap = t_lo;
          t_lo = t_hi;
          t_hi = swap;
        end
        if (t_lo > near_t) near_t = t_lo;
        if (t_hi < far_t) far_t = t_hi;
        if (near_t > far_t) ok = 1'b0;
      end
    end
    s.hit = ok;
    s.t_near = ok ? near_t : '0;
    s.t_far = ok ? far_t : '0;
    return s;
  endfunction

  function automatic ray_t make_ray(input fix_t ox, input fix_t oy, input fix_t oz,
                                    input fix_t ix, input fix_t iy, input fix_t iz,
                                    input logic [2:0] par);
    ray_t r;
    r.org[0] = ox;
    r.org[1] = oy;
    r.org[2] = oz;
    r.inv[0] = ix;
    r.inv[1] = iy;
    r.inv[2] = iz;
    r.par = par;
    return r;
  endfunction

  function automatic box_t make_box(input fix_t lx, input fix_t ly, input fix_t lz,
                                    input fix_t hx, input fix_t hy, input fix_t hz);
    box_t b;
    b.lo[0] = lx;
    b.lo[1] = ly;
    b.lo[2] = lz;
    b.hi[0] = hx;
    b.hi[1] = hy;
    b.hi[2] = hz;
    return b;
  endfunction

  function automatic void add_row(input logic [2:0] sel, input box_t b, input logic known,
                                  input logic h, input fix_t tn, input fix_t tf);
    box_row_t row;
    row.ray_sel = sel;
    row.box = b;
    row.known = known;
    row.want.hit = h;
    row.want.t_near = tn;
    row.want.t_far = tf;
    directed_rows.push_back(row);
  endfunction

  // Coordinates: a quarter anywhere in range, the rest within eight units of zero.
  function automatic fix_t rand_coord();
    if ($urandom_range(0, 3) == 0) return fix_t'($urandom());
    return fix_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // Reciprocal directions: full range, zero, extremes or moderate values.
  function automatic fix_t rand_inv();
    unique case ($urandom_range(0, 5))
      0: return fix_t'($urandom());
      1: return '0;
      5: return ($urandom_range(0, 1) == 0) ? FIX_MAX : FIX_MIN;
      default: return fix_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    int   i;
    for (i = 0; i < 3; i++) begin
      r.org[i] = rand_coord();
      r.inv[i] = rand_inv();
    end
    r.par = ($urandom_range(0, 1) == 0) ? 3'b000 : 3'($urandom_range(0, 7));
    return r;
  endfunction

  // Boxes mostly lie near the origin so that hits are common; some are
  // anywhere at all, and some have one axis turned inside out.
  function automatic box_t rand_box(input ray_t r);
    box_t b;
    fix_t c, h, t;
    int   i, k;
    if ($urandom_range(0, 9) == 0) begin
      for (i = 0; i < 3; i++) begin
        b.lo[i] = fix_t'($urandom());
        b.hi[i] = fix_t'($urandom());
      end
      return b;
    end
    for (i = 0; i < 3; i++) begin
      c = r.org[i] + fix_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      h = fix_t'($urandom_range(0, 32'h0003_0000));
      b.lo[i] = c - h;
      b.hi[i] = c + h;
    end
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 2);
      t = b.lo[k];
      b.lo[k] = b.hi[k];
      b.hi[k] = t;
    end
    return b;
  endfunction

  // One register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      rbst_pkg::REG_ORIGIN_X:  cur_ray.org[0] = data;
      rbst_pkg::REG_ORIGIN_Y:  cur_ray.org[1] = data;
      rbst_pkg::REG_ORIGIN_Z:  cur_ray.org[2] = data;
      rbst_pkg::REG_INV_DIR_X: cur_ray.inv[0] = data;
      rbst_pkg::REG_INV_DIR_Y: cur_ray.inv[1] = data;
      rbst_pkg::REG_INV_DIR_Z: cur_ray.inv[2] = data;
      rbst_pkg::REG_PARALLEL:  cur_ray.par = data[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Loads a whole ray; the parallel mask goes out with random upper bits.
  task automatic load_ray(input ray_t r, input bit with_spare);
    if (with_spare) write_reg(REG_SPARE, $urandom());
    write_reg(rbst_pkg::REG_ORIGIN_X, r.org[0]);
    write_reg(rbst_pkg::REG_ORIGIN_Y, r.org[1]);
    write_reg(rbst_pkg::REG_ORIGIN_Z, r.org[2]);
    write_reg(rbst_pkg::REG_INV_DIR_X, r.inv[0]);
    write_reg(rbst_pkg::REG_INV_DIR_Y, r.inv[1]);
    write_reg(rbst_pkg::REG_INV_DIR_Z, r.inv[2]);
    write_reg(rbst_pkg::REG_PARALLEL, ($urandom() & 32'hffff_fff8) | 32'(r.par));
    cfg_valid <= 1'b0;
    ray_settings++;
  endtask

  // Offers one box after an optional gap and records what it should produce.
  task automatic push_box(input box_t b, input logic known, input span_t want, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    box_min_x <= b.lo[0];
    box_min_y <= b.lo[1];
    box_min_z <= b.lo[2];
    box_max_x <= b.hi[0];
    box_max_y <= b.hi[1];
    box_max_z <= b.hi[2];
    do @(posedge clk); while (in_stall);
    expected_spans.push_back(known ? want : predict_span(cur_ray, b));
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result side: random stall runs, switched off entirely in quiet phases.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!recv_busy) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        stall_left = pick_gap(1'b1);
      end
    end
  end

  // Compares each accepted result with the oldest owed span.
  always @(posedge clk) begin : check_results
    span_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        error_count++;
        $display("%0t: result arrived with nothing expected (hit %0d)", $time, hit);
      end else begin
        want = expected_spans.pop_front();
        spans_checked++;
        if (want.hit) hits_seen++;
        if (hit !== want.hit) begin
          error_count++;
          $display("%0t: hit expected %0d got %0d", $time, want.hit, hit);
        end
        if (t_near !== want.t_near) begin
          error_count++;
          $display("%0t: t_near expected %0d got %0d", $time,
                   $signed(want.t_near), $signed(t_near));
        end
        if (t_far !== want.t_far) begin
          error_count++;
          $display("%0t: t_far expected %0d got %0d", $time,
                   $signed(want.t_far), $signed(t_far));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    box_row_t   row;
    ray_t       r;
    logic [2:0] cur_sel;
    int         p, n;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    box_min_x = '0;
    box_min_y = '0;
    box_min_z = '0;
    box_max_x = '0;
    box_max_y = '0;
    box_max_z = '0;
    cur_ray = '0;
    error_count = 0;
    spans_checked = 0;
    hits_seen = 0;
    ray_settings = 1;
    send_busy = 1'b1;
    recv_busy = 1'b1;

    // Ray 0 is the reset state: zero reciprocals fold every axis to [0, 0].
    rays[0] = '0;
    // Ray 1: every axis parallel, so only the origin-in-slab tests matter.
    rays[1] = make_ray(ONE, -ONE, 0, 3 * ONE, -ONE, ONE, 3'b111);
    // Ray 2: an ordinary ray from the origin with small whole reciprocals.
    rays[2] = make_ray(0, 0, 0, ONE, 2 * ONE, -4 * ONE, 3'b000);
    // Ray 3: extreme origin and reciprocals, which drive the products to saturation.
    rays[3] = make_ray(FIX_MIN, FIX_MAX, 0, FIX_MAX, FIX_MIN, FIX_MIN, 3'b000);
    // Ray 4: one parallel axis and one zero reciprocal on a normal axis.
    rays[4] = make_ray(0, ONE / 2, -ONE, 0, 5 * ONE, -ONE, 3'b010);

    add_row(0, make_box(0, 0, 0, 0, 0, 0), 1, 1, 0, 0);
    add_row(0, make_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX), 1, 1, 0, 0);
    add_row(0, make_box(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN), 1, 1, 0, 0);
    add_row(1, make_box(-2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE),
            1, 1, FIX_MIN, FIX_MAX);
    add_row(1, make_box(-2 * ONE, -2 * ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE), 1, 0, 0, 0);
    add_row(1, make_box(2 * ONE, -2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE),
            1, 0, 0, 0);
    add_row(1, make_box(ONE, -ONE, 0, ONE, -ONE, 0), 1, 1, FIX_MIN, FIX_MAX);
    add_row(1, make_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX),
            1, 1, FIX_MIN, FIX_MAX);
    add_row(2, make_box(ONE, -ONE, -ONE, 3 * ONE, ONE, ONE), 1, 1, ONE, 2 * ONE);
    add_row(2, make_box(-3 * ONE, -ONE, -ONE, -ONE, ONE, ONE), 0, 0, 0, 0);
    add_row(2, make_box(ONE, 5 * ONE, -ONE, 3 * ONE, 6 * ONE, ONE), 0, 0, 0, 0);
    add_row(2, make_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX), 0, 0, 0, 0);
    add_row(3, make_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX), 0, 0, 0, 0);
    add_row(3, make_box(FIX_MAX, FIX_MIN, -ONE, FIX_MAX, FIX_MIN, ONE), 0, 0, 0, 0);
    add_row(3, make_box(0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
    add_row(4, make_box(-ONE, 0, -2 * ONE, ONE, ONE, 0), 0, 0, 0, 0);
    add_row(4, make_box(-ONE, ONE, -2 * ONE, ONE, 2 * ONE, 0), 0, 0, 0, 0);
    add_row(4, make_box(ONE, 0, ONE, 2 * ONE, ONE, 2 * ONE), 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; the ray is reloaded whenever the row asks for another.
    cur_sel = 3'd0;
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.ray_sel != cur_sel) begin
        wait_idle();
        load_ray(rays[row.ray_sel], 1'b0);
        cur_sel = row.ray_sel;
      end
      push_box(row.box, row.known, row.want, pick_gap(send_busy));
    end

    // Random phases, each with its own ray and its own pattern of idling.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      r = rand_ray();
      load_ray(r, $urandom_range(0, 2) == 0);
      send_busy = ($urandom_range(0, 3) != 0);
      recv_busy = ($urandom_range(0, 3) != 0);
      for (n = 0; n < BOXES_PER_PHASE; n++) begin
        push_box(rand_box(cur_ray), 1'b0, '0, pick_gap(send_busy));
      end
    end

    wait_idle();
    $display("Checked %0d boxes (%0d hits) against %0d ray settings,",
             spans_checked, hits_seen, ray_settings);
    $display("including parallel, zero-reciprocal, inverted and saturating cases.");
    if (error_count == 0) begin
      $display("ray_box_slab_test_tb: clean");
    end else begin
      $display("ray_box_slab_test_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rbst_pkg.sv
rtl/core/rbst_slab_lane.sv
rtl/core/rbst_fold.sv
rtl/core/ray_box_slab_test.sv
sim/ray_box_slab_test_tb.sv
